// File: design/rapd_pkg.sv
// Shared types and constants for the range average presence debounce block.
package rapd_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd100;
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET  = 16'd500;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 1'b0,
    REG_DEBOUNCE  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic                sample_valid;
    logic [SAMPLE_W-1:0] range_sample;
    logic [TIME_W-1:0]   now_ms;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average_range;
    logic                present;
    logic                changed;
  } out_item_t;

endpackage

// File: design/rapd_if.sv
// Valid/ready stream interfaces for the input and result channels.
interface rapd_in_if;
  import rapd_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface rapd_out_if;
  import rapd_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: design/rapd_cell.sv
// One cell of the sample window: holds a sample and passes it on when shifting.
module rapd_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          shift_i,
  input  logic [rapd_pkg::SAMPLE_W-1:0] sample_i,
  output logic [rapd_pkg::SAMPLE_W-1:0] sample_o
);
  import rapd_pkg::*;

  logic [SAMPLE_W-1:0] sample_q;

  // Take the neighbor's sample on each shift; window starts as zeros
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (shift_i) begin
      sample_q <= sample_i;
    end
  end

  assign sample_o = sample_q;

endmodule

// File: design/rapd_debounce.sv
// Presence flag with time-based debounce of threshold mismatches.
module rapd_debounce (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [rapd_pkg::SAMPLE_W-1:0] avg_i,
  input  logic [rapd_pkg::TIME_W-1:0]   now_i,
  input  logic [rapd_pkg::CFG_W-1:0]    threshold_i,
  input  logic [rapd_pkg::CFG_W-1:0]    debounce_i,
  output logic                          present_o,
  output logic                          changed_o
);
  import rapd_pkg::*;

  logic              present_q, present_d;
  logic              mismatch_q, mismatch_d;
  logic [TIME_W-1:0] start_q, start_d;
  logic              below;
  logic [TIME_W-1:0] elapsed;
  logic              toggle;

  // Evaluate mismatch, restart the timer on a fresh mismatch, toggle when it outlasts debounce
  always_comb begin
    below      = avg_i < threshold_i;
    mismatch_d = below != present_q;
    start_d    = (mismatch_d && !mismatch_q) ? now_i : start_q;
    elapsed    = now_i - start_d;
    toggle     = mismatch_d && (elapsed > {{(TIME_W-CFG_W){1'b0}}, debounce_i});
    present_d  = present_q ^ toggle;
  end

  assign present_o = present_d;
  assign changed_o = toggle;

  // Hold debounce state between items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q  <= 1'b1;
      mismatch_q <= 1'b1;
      start_q    <= '0;
    end else if (step_i) begin
      present_q  <= present_d;
      mismatch_q <= mismatch_d;
      start_q    <= start_d;
    end
  end

endmodule

// File: design/range_average_presence_debounce_core.sv
// Top level: sample window chain, running sum, average and debounced presence.
//
//  channel  | dir | handshake   | payload
//  ---------+-----+-------------+----------------------------------------------
//  in_i     | in  | valid/ready | sample_valid, range_sample, now_ms
//  out_o    | out | valid/ready | average_range, present, changed
//  cfg      | in  | cfg_we_i    | cfg_idx_i selects register, cfg_data_i value
//
//  One item enters per cycle while the pipeline is not backed up; its result passes through
//  three registers (sum snapshot, reciprocal product, debounce and output register).
//  The running sum and debounce state update once per item, so items can follow back to back.
//  Reset clears the window cells, the sum, the pipeline valid flags and restores registers.
//  A stalled output backs up the pipeline; input stays ready while any stage is free.
module range_average_presence_debounce_core #(
  parameter int unsigned WINDOW = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rapd_in_if.sink                        in_i,
  rapd_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [rapd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rapd_pkg::CFG_W-1:0]     cfg_data_i
);
  import rapd_pkg::*;

  localparam int unsigned CLOG_W  = $clog2(WINDOW);
  localparam int unsigned SUM_W   = SAMPLE_W + CLOG_W;
  localparam int unsigned SHIFT   = SUM_W + CLOG_W;
  localparam int unsigned RECIP_W = SHIFT - CLOG_W + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam logic [63:0] RECIP64 =
    ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RECIP_W-1:0] RECIP   = RECIP64[RECIP_W-1:0];
  localparam logic [SUM_W-1:0]   SUM_MAX = SUM_W'(64'(WINDOW) * 64'd65535);

  // Configuration registers
  logic [CFG_W-1:0] threshold_q, debounce_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
      debounce_q  <= DEBOUNCE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_THRESHOLD: threshold_q <= cfg_data_i;
        REG_DEBOUNCE:  debounce_q  <= cfg_data_i;
        default:       threshold_q <= threshold_q;
      endcase
    end
  end

  // Stage enables, chained back from the output register
  logic v_a_q, v_b_q, v_out_q;
  logic en_a, en_b, en_out, accept, shift;

  assign en_out    = !v_out_q || out_o.ready;
  assign en_b      = !v_b_q || en_out;
  assign en_a      = !v_a_q || en_b;
  assign in_i.ready = en_a;
  assign accept    = in_i.valid && en_a;
  assign shift     = accept && in_i.payload.sample_valid;

  // Sample window as a chain of cells; the last cell holds the oldest sample
  logic [SAMPLE_W-1:0] cell_q [WINDOW];

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    if (k == 0) begin : g_head
      rapd_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .shift_i  (shift),
        .sample_i (in_i.payload.range_sample),
        .sample_o (cell_q[k])
      );
    end else begin : g_body
      rapd_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .shift_i  (shift),
        .sample_i (cell_q[k-1]),
        .sample_o (cell_q[k])
      );
    end
  end

  // Running sum: add the new sample, drop the oldest
  logic [SUM_W-1:0] sum_q, sum_d;

  always_comb begin
    sum_d = sum_q;
    if (shift) begin
      sum_d = sum_q - SUM_W'(cell_q[WINDOW-1]) + SUM_W'(in_i.payload.range_sample);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  // Stage A: snapshot of the sum after this item
  logic [SUM_W-1:0]  sum_a_q;
  logic [TIME_W-1:0] now_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
    end else if (en_a) begin
      v_a_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sum_a_q <= sum_d;
      now_a_q <= in_i.payload.now_ms;
    end
  end

  // Stage B: divide by the window through an exact reciprocal multiply
  logic [PROD_W-1:0] prod_q;
  logic [TIME_W-1:0] now_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_b_q <= 1'b0;
    end else if (en_b) begin
      v_b_q <= v_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b && v_a_q) begin
      prod_q  <= PROD_W'(sum_a_q) * PROD_W'(RECIP);
      now_b_q <= now_a_q;
    end
  end

  // Stage C: debounce and output register
  logic [SAMPLE_W-1:0] avg_b;
  logic                step;
  logic                present, changed;
  out_item_t           out_q;

  assign avg_b = prod_q[SHIFT +: SAMPLE_W];
  assign step  = en_out && v_b_q;

  rapd_debounce u_debounce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .avg_i       (avg_b),
    .now_i       (now_b_q),
    .threshold_i (threshold_q),
    .debounce_i  (debounce_q),
    .present_o   (present),
    .changed_o   (changed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_out_q <= 1'b0;
    end else if (en_out) begin
      v_out_q <= v_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q.average_range <= avg_b;
      out_q.present       <= present;
      out_q.changed       <= changed;
    end
  end

  assign out_o.valid   = v_out_q;
  assign out_o.payload = out_q;

  // Running sum never exceeds a full window of maximum samples
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= SUM_MAX)
    else $error("window sum out of range");

  // Reciprocal product leaves no quotient bits above the sample width
  a_avg_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_b_q |-> (prod_q >> (SHIFT + SAMPLE_W)) == '0)
    else $error("average exceeds sample width");

  // Input is held off only when every stage is full and the output is stalled
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (v_a_q && v_b_q && v_out_q && !out_o.ready))
    else $error("input stalled with a free stage");

endmodule
